// ----- design/button_debounce_with_repeat_macros.svh -----
// Assertion macros used by the button debouncer top level.
`ifndef BUTTON_DEBOUNCE_WITH_REPEAT_MACROS_SVH
`define BUTTON_DEBOUNCE_WITH_REPEAT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BDR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- design/bdr_pkg.sv -----
// Types and constants shared by the button debouncer modules.
`default_nettype none

package bdr_pkg;

  localparam int TimeW   = 32;
  localparam int CfgW    = 16;
  localparam int CfgIdxW = 2;

  // Register reset values.
  localparam logic [CfgW-1:0] ThrPressRst   = CfgW'(50);
  localparam logic [CfgW-1:0] ThrReleaseRst = CfgW'(50);
  localparam logic [CfgW-1:0] RepeatIvlRst  = CfgW'(0);

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_READ   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_DOWN   = 2'd1,
    EV_UP     = 2'd2,
    EV_REPEAT = 2'd3
  } ev_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THR_PRESS   = 2'd0,
    CFG_THR_RELEASE = 2'd1,
    CFG_REPEAT_IVL  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    op_e              opcode;
    logic [TimeW-1:0] time_ms;
    logic             level;
  } item_t;

  typedef struct packed {
    logic pressed;
    ev_e  event_code;
  } result_t;

  typedef struct packed {
    logic               valid;
    logic [CfgIdxW-1:0] index;
    logic [CfgW-1:0]    data;
  } cfg_wr_t;

  typedef struct packed {
    logic held;
    ev_e  pending;
  } status_t;

endpackage

`default_nettype wire

// ----- design/bdr_ifs.sv -----
// Handshake interfaces for the item, result and configuration channels.
`default_nettype none

interface bdr_item_if import bdr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [TimeW-1:0] time_ms;
  logic             level;

  modport source (output valid, opcode, time_ms, level, input ready);
  modport sink   (input valid, opcode, time_ms, level, output ready);
endinterface

interface bdr_result_if;
  logic       valid;
  logic       ready;
  logic       pressed;
  logic [1:0] event_code;

  modport source (output valid, pressed, event_code, input ready);
  modport sink   (input valid, pressed, event_code, output ready);
endinterface

interface bdr_cfg_if import bdr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/button_debounce_with_repeat.sv -----
// Top level of the active-low button debouncer with auto-repeat.
`default_nettype none

`include "button_debounce_with_repeat_macros.svh"

// Debounces an active-low button sampled by update items carrying a
// millisecond timestamp, and reports down, up and repeat events through
// read items that return and clear the latched event. Every item gives one
// result. An item is taken into an input register, runs through the update
// logic once the result queue has room and lands in that two-entry queue,
// from which its result is offered to the sink. One item is taken per cycle
// as long as the result queue has room; the queue lets a new item in while
// an earlier result still waits for the sink. Configuration writes are taken
// at any time but must only be issued while the block is idle.
module button_debounce_with_repeat import bdr_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  bdr_cfg_if.sink        cfg_i,
  bdr_item_if.sink       item_i,
  bdr_result_if.source   result_o
);

  localparam int QDepth = 2;

  logic    in_valid_q;
  item_t   item_q;
  logic    advance;
  cfg_wr_t cfg_wr;
  result_t core_result;
  status_t core_status;

  result_t                    queue_q [QDepth];
  logic                       wr_ptr_q, rd_ptr_q;
  logic [$clog2(QDepth+1)-1:0] count_q;
  logic                       q_full;
  logic                       push, pop;

  // Configuration channel is always ready.
  assign cfg_i.ready  = 1'b1;
  assign cfg_wr.valid = cfg_i.valid;
  assign cfg_wr.index = cfg_i.index;
  assign cfg_wr.data  = cfg_i.data;

  // Input register stage.
  assign q_full       = (count_q == ($clog2(QDepth+1))'(QDepth));
  assign advance      = in_valid_q && !q_full;
  assign item_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      in_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      item_q.opcode  <= op_e'(item_i.opcode);
      item_q.time_ms <= item_i.time_ms;
      item_q.level   <= item_i.level;
    end
  end

  // Debounce state and update logic.
  bdr_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_wr),
    .step_i   (advance),
    .item_i   (item_q),
    .result_o (core_result),
    .status_o (core_status)
  );

  // Result queue.
  assign push = advance;
  assign pop  = result_o.valid && result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= core_result;
    end
  end

  assign result_o.valid      = (count_q != '0);
  assign result_o.pressed    = queue_q[rd_ptr_q].pressed;
  assign result_o.event_code = queue_q[rd_ptr_q].event_code;

  // Checks on the pipeline and the event latch.
  `BDR_ASSERT_NOW(a_update_no_code, clk_i, rst_ni,
                  advance && item_q.opcode == OP_UPDATE,
                  core_result.event_code == EV_NONE)
  `BDR_ASSERT_NEXT(a_read_clears, clk_i, rst_ni,
                   advance && item_q.opcode == OP_READ,
                   core_status.pending == EV_NONE)
  `BDR_ASSERT_NEXT(a_pressed_is_state, clk_i, rst_ni,
                   advance,
                   core_status.held == $past(core_result.pressed))
  `BDR_ASSERT_NOW(a_full_blocks_input, clk_i, rst_ni,
                  q_full && in_valid_q,
                  !item_i.ready)

endmodule

`default_nettype wire

// ----- design/bdr_core.sv -----
// Debounce state, configuration registers and the per-item update logic.
`default_nettype none

module bdr_core import bdr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_wr_t cfg_i,
  input  logic    step_i,
  input  item_t   item_i,
  output result_t result_o,
  output status_t status_o
);

  logic [CfgW-1:0]  thr_press_q, thr_release_q, repeat_ivl_q;
  logic             prev_level_q, prev_level_d;
  logic [TimeW-1:0] change_time_q, change_time_d;
  logic             held_q, held_d;
  ev_e              pending_q, pending_d;
  logic [TimeW-1:0] repeat_time_q, repeat_time_d;

  logic [CfgW-1:0]  thr;
  logic [TimeW-1:0] change_limit;
  logic [TimeW-1:0] repeat_limit;
  ev_e              code;

  // Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_press_q   <= ThrPressRst;
      thr_release_q <= ThrReleaseRst;
      repeat_ivl_q  <= RepeatIvlRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_THR_PRESS:   thr_press_q   <= cfg_i.data;
        CFG_THR_RELEASE: thr_release_q <= cfg_i.data;
        CFG_REPEAT_IVL:  repeat_ivl_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Deadlines wrap at 32 bits.
  assign thr          = held_q ? thr_release_q : thr_press_q;
  assign change_limit = change_time_q + TimeW'(thr);
  assign repeat_limit = repeat_time_q + TimeW'(repeat_ivl_q);

  // Next state for one item.
  always_comb begin
    prev_level_d  = prev_level_q;
    change_time_d = change_time_q;
    held_d        = held_q;
    pending_d     = pending_q;
    repeat_time_d = repeat_time_q;
    code          = EV_NONE;
    if (step_i) begin
      case (item_i.opcode)
        OP_UPDATE: begin
          if (item_i.time_ms < change_time_q) begin
            // Time went backwards: restart both timers and stop there.
            change_time_d = item_i.time_ms;
            repeat_time_d = item_i.time_ms;
          end else begin
            if (item_i.level != prev_level_q) begin
              change_time_d = item_i.time_ms;
            end else if (item_i.time_ms >= change_limit) begin
              if (!item_i.level && !held_q) begin
                held_d        = 1'b1;
                pending_d     = EV_DOWN;
                repeat_time_d = item_i.time_ms;
              end else if (item_i.level && held_q) begin
                held_d    = 1'b0;
                pending_d = EV_UP;
              end
            end
            prev_level_d = item_i.level;
            // A fresh down event blocks the repeat check, so the old
            // repeat time is the right base here.
            if (repeat_ivl_q != '0 && held_d && pending_d == EV_NONE &&
                item_i.time_ms >= repeat_limit) begin
              pending_d     = EV_REPEAT;
              repeat_time_d = item_i.time_ms;
            end
          end
        end
        OP_READ: begin
          code      = pending_q;
          pending_d = EV_NONE;
        end
        default: ;
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_level_q  <= 1'b0;
      change_time_q <= '0;
      held_q        <= 1'b0;
      pending_q     <= EV_NONE;
      repeat_time_q <= '0;
    end else begin
      prev_level_q  <= prev_level_d;
      change_time_q <= change_time_d;
      held_q        <= held_d;
      pending_q     <= pending_d;
      repeat_time_q <= repeat_time_d;
    end
  end

  assign result_o.pressed    = held_d;
  assign result_o.event_code = code;
  assign status_o.held       = held_q;
  assign status_o.pending    = pending_q;

endmodule

`default_nettype wire

// ----- verif/tb_button_debounce_with_repeat.sv -----
// Self-checking testbench for the active-low button debouncer with auto-repeat.
module tb_button_debounce_with_repeat;
  timeunit 1ns;
  timeprecision 1ps;
  import bdr_pkg::*;

  // Mirror of the debouncer state that predicts the result of every item.
  class debounce_mirror;
    logic [CfgW-1:0]  thr_press;
    logic [CfgW-1:0]  thr_release;
    logic [CfgW-1:0]  repeat_ivl;
    logic             prev_level;
    logic [TimeW-1:0] change_time;
    logic [TimeW-1:0] repeat_time;
    logic             held;
    ev_e              latched;
    result_t          due_results[$];
    int               errors;
    int               checked;
    int               n_down;
    int               n_up;
    int               n_repeat;
    int               n_backwards;

    function new();
      thr_press   = ThrPressRst;
      thr_release = ThrReleaseRst;
      repeat_ivl  = RepeatIvlRst;
      prev_level  = 1'b0;
      change_time = '0;
      repeat_time = '0;
      held        = 1'b0;
      latched     = EV_NONE;
      errors      = 0;
      checked     = 0;
      n_down      = 0;
      n_up        = 0;
      n_repeat    = 0;
      n_backwards = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CfgW-1:0] value);
      case (idx)
        CFG_THR_PRESS:   thr_press = value;
        CFG_THR_RELEASE: thr_release = value;
        CFG_REPEAT_IVL:  repeat_ivl = value;
        default: ;
      endcase
    endfunction

    // Advance the mirror by one accepted item and queue the result it gives.
    function void take_item(item_t it);
      result_t          res;
      logic [TimeW-1:0] limit;
      res.event_code = EV_NONE;
      if (it.opcode == OP_READ) begin
        res.event_code = latched;
        case (latched)
          EV_DOWN:   n_down++;
          EV_UP:     n_up++;
          EV_REPEAT: n_repeat++;
          default: ;
        endcase
        latched = EV_NONE;
      end else if (it.time_ms < change_time) begin
        // Time went backwards: both timers restart and nothing else happens.
        change_time = it.time_ms;
        repeat_time = it.time_ms;
        n_backwards++;
      end else begin
        if (it.level != prev_level) begin
          change_time = it.time_ms;
        end else begin
          limit = change_time + TimeW'(held ? thr_release : thr_press);
          if (it.time_ms >= limit) begin
            if (!it.level && !held) begin
              held        = 1'b1;
              latched     = EV_DOWN;
              repeat_time = it.time_ms;
            end else if (it.level && held) begin
              held    = 1'b0;
              latched = EV_UP;
            end
          end
        end
        prev_level = it.level;
        // Auto-repeat fires only while held with nothing latched.
        limit = repeat_time + TimeW'(repeat_ivl);
        if (repeat_ivl != '0 && held && latched == EV_NONE && it.time_ms >= limit) begin
          latched     = EV_REPEAT;
          repeat_time = it.time_ms;
        end
      end
      res.pressed = held;
      due_results.push_back(res);
    endfunction

    // Compare one result transfer with the oldest prediction.
    function void match_result(logic pressed, logic [1:0] code);
      result_t want;
      if (due_results.size() == 0) begin
        $display("%0t ns: result with nothing predicted: pressed=%0b event=%0d",
                 $time, pressed, code);
        errors++;
        return;
      end
      want = due_results.pop_front();
      checked++;
      if (pressed !== want.pressed) begin
        $display("%0t ns: pressed mismatch: expected %0b, actual %0b",
                 $time, want.pressed, pressed);
        errors++;
      end
      if (code !== want.event_code) begin
        $display("%0t ns: event_code mismatch: expected %0d, actual %0d",
                 $time, want.event_code, code);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  bdr_cfg_if    cfg_if();
  bdr_item_if   item_if();
  bdr_result_if result_if();

  button_debounce_with_repeat dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_if),
    .item_i   (item_if),
    .result_o (result_if)
  );

  debounce_mirror mirror = new();

  logic [TimeW-1:0] now_ms;
  int               burst_left;
  int               n_settings;

  // Clock with a 2 ns period.
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Hard limit on the run time.
  initial begin
    #2_000_000;
    $display("button_debounce_with_repeat test failed");
    $finish;
  end

  // Result side: check each transfer, then pick ready from a changing pattern.
  initial begin
    int mode;
    int mode_left;
    mode      = 0;
    mode_left = 0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && result_if.valid === 1'b1 && result_if.ready) begin
        mirror.match_result(result_if.pressed, result_if.event_code);
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(5, 60);
      end
      mode_left--;
      case (mode)
        0:       result_if.ready <= 1'b1;
        1:       result_if.ready <= 1'($urandom_range(0, 1));
        default: result_if.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Offer one item and hold it until the transfer; valid stays high afterwards.
  task automatic send_item(op_e op, logic [TimeW-1:0] t, logic lvl);
    item_t it;
    it.opcode  = op;
    it.time_ms = t;
    it.level   = lvl;
    item_if.valid   <= 1'b1;
    item_if.opcode  <= op;
    item_if.time_ms <= t;
    item_if.level   <= lvl;
    do @(posedge clk_i); while (!item_if.ready);
    mirror.take_item(it);
  endtask

  // Bursts of back-to-back items separated by random gaps.
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 30);
    end
  endtask

  task automatic update(logic [TimeW-1:0] t, logic lvl);
    send_item(OP_UPDATE, t, lvl);
    pace();
  endtask

  // Read items carry random time and level, which the block must ignore.
  task automatic read_event();
    send_item(OP_READ, $urandom, 1'($urandom_range(0, 1)));
    pace();
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic drain();
    item_if.valid <= 1'b0;
    @(posedge clk_i);
    while (mirror.due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write all three registers; only called while the block is idle.
  task automatic write_settings(logic [CfgW-1:0] p, logic [CfgW-1:0] r,
                                logic [CfgW-1:0] ivl);
    cfg_idx_e        idx [3];
    logic [CfgW-1:0] val [3];
    idx = '{CFG_THR_PRESS, CFG_THR_RELEASE, CFG_REPEAT_IVL};
    val = '{p, r, ivl};
    for (int k = 0; k < 3; k++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx[k];
      cfg_if.data  <= val[k];
      do @(posedge clk_i); while (!cfg_if.ready);
      mirror.write_reg(idx[k], val[k]);
    end
    cfg_if.valid <= 1'b0;
    n_settings++;
  endtask

  // Stimulus: directed cases, then randomized press and release sequences.
  initial begin
    logic [CfgW-1:0] set_press [8];
    logic [CfgW-1:0] set_rel   [8];
    logic [CfgW-1:0] set_ivl   [8];
    int              scale;
    int              run_left;
    int              pick;
    int              dt;
    logic            target;
    logic            lvl;

    set_press = '{16'd0, 16'd65535, 16'd3,  16'd20, 16'd1, 16'd0,     16'd9,  16'd0};
    set_rel   = '{16'd0, 16'd65535, 16'd12, 16'd5,  16'd1, 16'd65535, 16'd40, 16'd0};
    set_ivl   = '{16'd1, 16'd65535, 16'd4,  16'd0,  16'd2, 16'd7,     16'd15, 16'd0};

    n_settings = 0;
    burst_left = 0;
    now_ms     = '0;
    rst_ni          <= 1'b0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= CFG_THR_PRESS;
    cfg_if.data     <= '0;
    item_if.valid   <= 1'b0;
    item_if.opcode  <= OP_UPDATE;
    item_if.time_ms <= '0;
    item_if.level   <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset settings: bounce, press at the exact threshold, release, backwards time.
    update(32'd10, 1'b1);
    update(32'd20, 1'b0);
    update(32'd69, 1'b0);
    update(32'd70, 1'b0);
    read_event();
    read_event();
    update(32'd80, 1'b1);
    update(32'd130, 1'b1);
    read_event();
    update(32'd40, 1'b1);
    update(32'd45, 1'b0);
    send_item(OP_READ, 32'hFFFF_FFFF, 1'b1);
    drain();

    // Zero press threshold, widest release threshold, repeat every millisecond.
    write_settings(16'd0, 16'd65535, 16'd1);
    update(32'd45, 1'b0);
    update(32'd46, 1'b0);
    read_event();
    update(32'd47, 1'b0);
    read_event();
    update(32'hFFFF_FFF0, 1'b1);
    update(32'hFFFF_FFFF, 1'b1);
    read_event();
    update(32'd5, 1'b1);
    send_item(OP_READ, 32'h0000_0000, 1'b0);
    drain();

    // Random part: one phase per register setting.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) begin
        write_settings(16'($urandom_range(0, 60)), 16'($urandom_range(0, 60)),
                       16'($urandom_range(0, 20)));
      end else begin
        write_settings(set_press[ph], set_rel[ph], set_ivl[ph]);
      end
      scale = 4;
      if (int'(mirror.thr_press) > scale) scale = int'(mirror.thr_press);
      if (int'(mirror.thr_release) > scale) scale = int'(mirror.thr_release);
      if (int'(mirror.repeat_ivl) > scale) scale = int'(mirror.repeat_ivl);
      // Some phases start just below the top of the time range so sums wrap.
      if (ph == 1 || ph == 4) now_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 4 * scale));
      target   = 1'b1;
      run_left = 0;
      for (int n = 0; n < 190; n++) begin
        pick = $urandom_range(0, 99);
        if (n == 95 && ph == 2) begin
          drain();
        end
        if (pick < 20) begin
          read_event();
        end else if (pick < 23) begin
          now_ms = now_ms - 32'($urandom_range(1, scale));
          update(now_ms, 1'($urandom_range(0, 1)));
        end else if (pick < 25) begin
          now_ms = $urandom;
          update(now_ms, 1'($urandom_range(0, 1)));
        end else begin
          if (run_left == 0) begin
            target   = ~target;
            run_left = $urandom_range(3, 40);
          end
          run_left--;
          lvl = ($urandom_range(0, 99) < 15) ? ~target : target;
          dt  = ($urandom_range(0, 9) == 0) ? $urandom_range(scale / 2, 2 * scale)
                                            : $urandom_range(0, scale / 4 + 1);
          now_ms = now_ms + 32'(dt);
          update(now_ms, lvl);
        end
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    $display("Checked %0d results under %0d register settings.",
             mirror.checked, n_settings + 1);
    $display("Reads returned %0d down, %0d up and %0d repeat events; %0d updates went back in time.",
             mirror.n_down, mirror.n_up, mirror.n_repeat, mirror.n_backwards);
    if (mirror.errors == 0) begin
      $display("button_debounce_with_repeat test passed");
    end else begin
      $display("button_debounce_with_repeat test failed");
    end
    $finish;
  end

endmodule
